// ===== hdl/array_priority_queue_macros.svh =====
// assertion macros for the array priority queue
// included by modules that check their own control logic; no other dependencies
`ifndef ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define ARRAY_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTH
// property that must hold on every clock edge outside reset
`define APQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define APQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define APQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define APQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/apq_pkg.sv =====
// shared types and codes for the array priority queue
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package apq_pkg;

    localparam int APQ_DEPTH = 8;

    // command codes
    localparam logic [1:0] CMD_ENQ  = 2'd0;
    localparam logic [1:0] CMD_DEQ  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] rank;
    } entry_t;

    typedef struct packed {
        status_t     status;
        entry_t      data;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_START,
        S_SHIFT,
        S_HOLD
    } state_t;

endpackage

// ===== hdl/apq_mem.sv =====
// entry store: one write port, one read port with registered read data
// depends on apq_pkg for the entry type
`timescale 1ns / 1ps

module apq_mem
    import apq_pkg::*;
#(
    parameter int DEPTH = APQ_DEPTH,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/apq_out.sv =====
// output register that holds a finished result until the sink takes the beat
// depends on apq_pkg for the result type
`timescale 1ns / 1ps

module apq_out
    import apq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    output logic    res_ready,
    input  result_t res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;

    // free when empty or when the held beat leaves this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// ===== hdl/apq_ctrl.sv =====
// command sequencer: fill count, scan for the best entry, shift-down after removal
// depends on apq_pkg and the assertion macros; drives apq_mem and apq_out
`timescale 1ns / 1ps
`include "array_priority_queue_macros.svh"

module apq_ctrl
    import apq_pkg::*;
#(
    parameter int DEPTH = APQ_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int FW    = $clog2(DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    cmd,
    input  entry_t        item,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output entry_t        mem_wdata,
    output logic [AW-1:0] mem_raddr,
    input  entry_t        mem_rdata,
    output logic          res_valid,
    input  logic          res_ready,
    output result_t       res
);

    state_t        state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [AW-1:0] didx_reg, didx_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    entry_t        best_reg, best_next;
    result_t       res_reg, res_next;
    logic          is_deq_reg, is_deq_next;

    logic          accept;
    logic          take;
    logic [AW-1:0] best_idx_cur;
    entry_t        best_cur;
    logic [FW-1:0] last_idx;
    logic          scan_last;
    logic          shift_last;
    logic          no_shift;

    assign accept = in_valid && in_ready;

    // compare the entry coming out of memory with the best so far
    assign take         = (didx_reg == '0) || (mem_rdata.rank > best_reg.rank);
    assign best_idx_cur = take ? didx_reg : best_idx_reg;
    assign best_cur     = take ? mem_rdata : best_reg;
    assign last_idx     = fill_reg - FW'(1);
    assign scan_last    = (FW'(didx_reg) == last_idx);
    assign shift_last   = ((FW'(didx_reg) + FW'(2)) == fill_reg);
    assign no_shift     = (FW'(best_idx_cur) == last_idx);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd == CMD_DEQ || cmd == CMD_PEEK) && fill_reg != '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    if (!is_deq_reg || no_shift)
                    begin
                        state_next = S_HOLD;
                    end
                    else
                    begin
                        state_next = S_SHIFT_START;
                    end
                end
            end
            S_SHIFT_START:
            begin
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (shift_last)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs, memory control and datapath next values
    always_comb
    begin
        in_ready      = (state_reg == S_IDLE);
        res_valid     = (state_reg == S_HOLD);
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = item;
        mem_raddr     = '0;
        fill_next     = fill_reg;
        didx_next     = didx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        res_next      = res_reg;
        is_deq_next   = is_deq_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '{status: ST_OK, data: '0};
                    if (cmd == CMD_ENQ)
                    begin
                        if (fill_reg >= FW'(DEPTH))
                        begin
                            res_next.status = ST_OVERFLOW;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = fill_reg[AW-1:0];
                            fill_next = fill_reg + FW'(1);
                        end
                    end
                    else if (cmd == CMD_DEQ || cmd == CMD_PEEK)
                    begin
                        if (fill_reg == '0)
                        begin
                            res_next.status = ST_UNDERFLOW;
                        end
                        else
                        begin
                            mem_raddr   = '0;
                            didx_next   = '0;
                            is_deq_next = (cmd == CMD_DEQ);
                        end
                    end
                end
            end
            S_SCAN:
            begin
                best_next     = best_cur;
                best_idx_next = best_idx_cur;
                if (scan_last)
                begin
                    res_next = '{status: ST_OK, data: best_cur};
                    if (is_deq_reg && no_shift)
                    begin
                        fill_next = fill_reg - FW'(1);
                    end
                end
                else
                begin
                    mem_raddr = didx_reg + AW'(1);
                    didx_next = didx_reg + AW'(1);
                end
            end
            S_SHIFT_START:
            begin
                // fetch the entry just after the removed one
                mem_raddr = best_idx_reg + AW'(1);
                didx_next = best_idx_reg;
            end
            S_SHIFT:
            begin
                // move entry didx+1 down into didx
                mem_we    = 1'b1;
                mem_waddr = didx_reg;
                mem_wdata = mem_rdata;
                if (shift_last)
                begin
                    fill_next = fill_reg - FW'(1);
                end
                else
                begin
                    mem_raddr = didx_reg + AW'(2);
                    didx_next = didx_reg + AW'(1);
                end
            end
            S_HOLD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign res = res_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        didx_reg     <= didx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
        is_deq_reg   <= is_deq_next;
    end

    `APQ_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= FW'(DEPTH), "fill count above depth")
    `APQ_ASSERT_NEXT(a_enq_grows, clk, rst_n, accept && cmd == CMD_ENQ && fill_reg < FW'(DEPTH), fill_reg == $past(fill_reg) + FW'(1), "enqueue did not grow the store")
    `APQ_ASSERT(a_scan_live, clk, rst_n, state_reg != S_SCAN || FW'(didx_reg) < fill_reg, "scan ran past live entries")
    `APQ_ASSERT(a_shift_live, clk, rst_n, state_reg != S_SHIFT || (FW'(didx_reg) + FW'(2)) <= fill_reg, "shift ran past live entries")
    `APQ_ASSERT_NEXT(a_hold_release, clk, rst_n, state_reg == S_HOLD && res_ready, state_reg == S_IDLE, "result beat not released")

endmodule

// ===== hdl/array_priority_queue.sv =====
// top level of the array priority queue: sequencer, entry store and output register
// depends on apq_pkg, apq_mem, apq_out and apq_ctrl
`timescale 1ns / 1ps
//
//  channel  handshake             payload
//  -------  --------------------  ---------------------------------
//  in       in_valid / in_ready   cmd, item_value, item_rank
//  out      out_valid / out_ready status, out_value, out_rank
//
//  the single read port of the entry store sets the pace of peek and dequeue:
//  one entry per cycle is scanned, then, when a dequeue removes an entry other
//  than the newest, one entry per cycle is moved down to close the gap.
//  reset clears the fill count and control; the store itself needs no clearing.
//  a held output beat does not stop the next command from being accepted.

module array_priority_queue
    import apq_pkg::*;
#(
    parameter int DEPTH = APQ_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] item_value,
    input  logic signed [31:0] item_rank,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] out_value,
    output logic signed [31:0] out_rank
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    entry_t        item;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;
    logic          res_valid;
    logic          res_ready;
    result_t       res;
    result_t       out_res;

    assign item = '{value: item_value, rank: item_rank};

    apq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .FW    (FW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .item      (item),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    apq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    apq_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign status    = out_res.status;
    assign out_value = out_res.data.value;
    assign out_rank  = out_res.data.rank;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for array_priority_queue: directed table, then random bursts
// depends on apq_pkg and the array_priority_queue rtl only

module tb_top;
    import apq_pkg::*;

    localparam int DEPTH          = APQ_DEPTH;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 930;
    localparam int PRESSURE_ITEMS = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4 * DEPTH + 8;
    localparam int CYCLE_LIMIT    = 250000;

    // the block ignores this code but still answers it
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic signed [31:0] RANK_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] RANK_MIN = 32'sh80000000;

    // traffic mix of a random burst
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    // one directed step; fixed rows carry their status, data is zero for them
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
        logic signed [31:0] rank;
        logic               fixed;
        status_t            want_status;
    } step_row_t;

    localparam int STEP_ROWS = 24;
    localparam step_row_t STEP_TABLE [STEP_ROWS] = '{
        // empty store
        '{CMD_DEQ,  32'sd0,         32'sd0,         1'b1, ST_UNDERFLOW},
        '{CMD_PEEK, 32'sd0,         32'sd0,         1'b1, ST_UNDERFLOW},
        '{CMD_NONE, 32'sd0,         32'sd0,         1'b1, ST_OK},
        // fill to the brim with extremes and rank ties
        '{CMD_ENQ,  32'sh7fffffff,  RANK_MIN,       1'b1, ST_OK},
        '{CMD_ENQ,  32'sh80000000,  RANK_MAX,       1'b1, ST_OK},
        '{CMD_ENQ,  32'sd0,         32'sd0,         1'b1, ST_OK},
        '{CMD_ENQ,  -32'sd1,        -32'sd1,        1'b1, ST_OK},
        '{CMD_ENQ,  32'sh55555555,  RANK_MAX,       1'b1, ST_OK},
        '{CMD_ENQ,  32'shaaaaaaaa,  RANK_MIN,       1'b1, ST_OK},
        '{CMD_ENQ,  32'sd1,         32'sd1,         1'b1, ST_OK},
        '{CMD_ENQ,  32'sd2,         RANK_MAX,       1'b1, ST_OK},
        // full store
        '{CMD_ENQ,  32'sd3,         32'sd3,         1'b1, ST_OVERFLOW},
        // oldest of the top ranks, removal from the middle
        '{CMD_PEEK, 32'sd0,         32'sd0,         1'b0, ST_OK},
        '{CMD_DEQ,  32'sd0,         32'sd0,         1'b0, ST_OK},
        '{CMD_DEQ,  32'sd0,         32'sd0,         1'b0, ST_OK},
        '{CMD_PEEK, 32'sd0,         32'sd0,         1'b0, ST_OK},
        '{CMD_NONE, -32'sd1,        -32'sd1,        1'b1, ST_OK},
        // drain the rest, ending on the two lowest ranks
        '{CMD_DEQ,  32'sd0,         32'sd0,         1'b0, ST_OK},
        '{CMD_DEQ,  32'sd0,         32'sd0,         1'b0, ST_OK},
        '{CMD_DEQ,  32'sd0,         32'sd0,         1'b0, ST_OK},
        '{CMD_DEQ,  32'sd0,         32'sd0,         1'b0, ST_OK},
        '{CMD_DEQ,  32'sd0,         32'sd0,         1'b0, ST_OK},
        '{CMD_DEQ,  32'sd0,         32'sd0,         1'b0, ST_OK},
        '{CMD_DEQ,  32'sd0,         32'sd0,         1'b1, ST_UNDERFLOW}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         cmd;
    logic signed [31:0] item_value;
    logic signed [31:0] item_rank;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic signed [31:0] out_rank;

    // shadow copy of the queue contents, oldest first
    logic signed [31:0] shadow_value [DEPTH];
    logic signed [31:0] shadow_rank [DEPTH];
    int                 shadow_fill;

    result_t answers_due [$];
    int      error_count;
    int      cycle_count;
    bit      hold_off_req;

    array_priority_queue #(.DEPTH(DEPTH)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .item_value (item_value),
        .item_rank  (item_rank),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .out_value  (out_value),
        .out_rank   (out_rank)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_fault(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // answer of the queue to one command, updating the shadow copy
    function automatic result_t queue_answer(input logic [1:0] op,
                                             input logic signed [31:0] v,
                                             input logic signed [31:0] r);
        result_t res;
        int      best;
        int      i;
        res.status     = ST_OK;
        res.data.value = '0;
        res.data.rank  = '0;
        case (op)
            CMD_ENQ:
            begin
                if (shadow_fill >= DEPTH)
                    res.status = ST_OVERFLOW;
                else
                begin
                    shadow_value[shadow_fill] = v;
                    shadow_rank[shadow_fill]  = r;
                    shadow_fill++;
                end
            end
            CMD_DEQ, CMD_PEEK:
            begin
                if (shadow_fill == 0)
                    res.status = ST_UNDERFLOW;
                else
                begin
                    // strict compare keeps the oldest of equal ranks
                    best = 0;
                    for (i = 1; i < shadow_fill; i++)
                        if (shadow_rank[i] > shadow_rank[best])
                            best = i;
                    res.data.value = shadow_value[best];
                    res.data.rank  = shadow_rank[best];
                    if (op == CMD_DEQ)
                    begin
                        for (i = best; i + 1 < shadow_fill; i++)
                        begin
                            shadow_value[i] = shadow_value[i + 1];
                            shadow_rank[i]  = shadow_rank[i + 1];
                        end
                        shadow_fill--;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // present one command beat and hold it until accepted; valid stays high
    task automatic offer_beat(input logic [1:0] op, input logic signed [31:0] v,
                              input logic signed [31:0] r, input bit fixed,
                              input status_t fixed_status);
        result_t model;
        result_t want;
        in_valid   <= 1'b1;
        cmd        <= op;
        item_value <= v;
        item_rank  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model = queue_answer(op, v, r);
        if (fixed)
        begin
            want.status     = fixed_status;
            want.data.value = '0;
            want.data.rank  = '0;
        end
        else
            want = model;
        answers_due.push_back(want);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    // small ranks make ties common, extremes test the signed compare
    function automatic logic signed [31:0] pick_rank();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $signed(32'($urandom_range(0, 8))) - 32'sd4;
        if (sel < 6)
            return ($urandom_range(0, 1) != 0) ? RANK_MAX : RANK_MIN;
        return $signed($urandom);
    endfunction

    function automatic logic [1:0] pick_op(input mix_t mix);
        int unsigned sel;
        int unsigned enq_cut;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            return CMD_NONE;
        if (sel < 15)
            return CMD_PEEK;
        case (mix)
            MIX_FILL:  enq_cut = 80;
            MIX_DRAIN: enq_cut = 40;
            default:   enq_cut = 58;
        endcase
        return (sel < enq_cut) ? CMD_ENQ : CMD_DEQ;
    endfunction

    // random burst; returns how many real commands went out
    task automatic random_burst(input int len, input mix_t mix, output int sent);
        logic [1:0] op;
        int         k;
        sent = 0;
        for (k = 0; k < len; k++)
        begin
            op = pick_op(mix);
            offer_beat(op, $signed($urandom), pick_rank(), 1'b0, ST_OK);
            if (op != CMD_NONE)
                sent++;
        end
    endtask

    // result beats: compare against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (answers_due.size() == 0)
                report_fault($sformatf("result beat with nothing expected, status %0d",
                                       status));
            else
            begin
                want = answers_due.pop_front();
                if (status !== want.status)
                    report_fault($sformatf("status got %0d want %0d", status, want.status));
                if (out_value !== want.data.value)
                    report_fault($sformatf("out_value got %h want %h",
                                           out_value, want.data.value));
                if (out_rank !== want.data.rank)
                    report_fault($sformatf("out_rank got %h want %h",
                                           out_rank, want.data.rank));
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int          mode;
        int          len;
        int          k;
        logic        rdy;
        bit          held;
        out_ready = 1'b0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 60);
            for (k = 0; k < len; k++)
            begin
                if (hold_off_req && !held)
                begin
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES)
                        @(posedge clk);
                    held = 1'b1;
                end
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = $urandom_range(0, 1) != 0;
                    2:       rdy = $urandom_range(0, 3) != 0;
                    default: rdy = $urandom_range(0, 3) == 0;
                endcase
                out_ready <= rdy;
                @(posedge clk);
            end
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // stimulus
    initial
    begin
        int   k;
        int   sent;
        int   real_items;
        int   gap;
        bit   pressure_done;
        mix_t mix;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = CMD_ENQ;
        item_value    = '0;
        item_rank     = '0;
        hold_off_req  = 1'b0;
        error_count   = 0;
        shadow_fill   = 0;
        pressure_done = 1'b0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (k = 0; k < STEP_ROWS; k++)
            offer_beat(STEP_TABLE[k].op, STEP_TABLE[k].value, STEP_TABLE[k].rank,
                       STEP_TABLE[k].fixed, STEP_TABLE[k].want_status);
        in_valid <= 1'b0;
        wait_drained();

        // random bursts with random gaps
        real_items = 0;
        while (real_items < RANDOM_ITEMS)
        begin
            if (!pressure_done && real_items >= RANDOM_ITEMS / 2)
            begin
                // receiver holds off while items keep coming, then full drain
                hold_off_req = 1'b1;
                random_burst(PRESSURE_ITEMS, MIX_EVEN, sent);
                real_items += sent;
                in_valid <= 1'b0;
                wait_drained();
                pressure_done = 1'b1;
            end
            else
            begin
                mix = mix_t'($urandom_range(0, 2));
                random_burst($urandom_range(1, 20), mix, sent);
                real_items += sent;
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap)
                        @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/apq_pkg.sv
hdl/apq_mem.sv
hdl/apq_out.sv
hdl/apq_ctrl.sv
hdl/array_priority_queue.sv
verif/tb_top.sv
